// ----- hw/rtl/itra_pkg.sv -----
// Shared types, constants and helpers for the integer to radix text converter.
package itra_pkg;

    localparam int NUMBER_W  = 32;   // width of the incoming integer field
    localparam int RADIX_W   = 6;    // width of the radix field
    localparam int CHAR_W    = 7;    // ASCII character width
    localparam int DIGIT_W   = 5;    // one digit of a radix up to 32
    localparam int EXT_BITS  = 64;   // widest converted word the block supports
    localparam int STEP_BITS = 8;    // quotient bits resolved per divider cycle

    localparam logic [RADIX_W-1:0] MIN_RADIX = 6'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX = 6'd32;
    localparam logic [RADIX_W-1:0] DEC_RADIX = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;   // '0'
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;   // 'A'
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;   // '-'

    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 5'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 5'd10;

    // Classification of one word, carried from the front end to the back end
    typedef struct packed {
        logic                 bad;     // radix outside the supported range
        logic                 minus;   // print a leading minus sign
        logic [RADIX_W-1:0]   radix;
    } item_ctrl_t;

    // Map a digit value to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d > DIGIT_NINE)
            ch = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        else
            ch = CHAR_ZERO + CHAR_W'(d);
        return ch;
    endfunction

endpackage

// ----- hw/rtl/itra_front.sv -----
// Front end: check the radix, take the sign and form the magnitude of a word.
module itra_front #(
    parameter int WORD_BITS = 32
) (
    input  logic signed [itra_pkg::NUMBER_W-1:0] number,
    input  logic [itra_pkg::RADIX_W-1:0]         radix,
    output itra_pkg::item_ctrl_t                 ctrl,
    output logic [WORD_BITS-1:0]                 mag
);
    import itra_pkg::*;

    logic [EXT_BITS-1:0]  ext;
    logic [WORD_BITS-1:0] word;
    logic                 neg;

    // Sign-extend the field, then cut it to the converted word width
    assign ext  = {{(EXT_BITS-NUMBER_W){number[NUMBER_W-1]}}, number};
    assign word = ext[WORD_BITS-1:0];
    assign neg  = word[WORD_BITS-1];

    // The most negative value negates to itself, which is the right unsigned magnitude
    assign mag = neg ? WORD_BITS'(~word + 1'b1) : word;

    // Classify the radix and decide on the sign character
    always_comb
    begin
        ctrl.bad   = (radix < MIN_RADIX) || (radix > MAX_RADIX);
        ctrl.minus = neg && (radix == DEC_RADIX);
        ctrl.radix = radix;
    end

endmodule

// ----- hw/rtl/itra_queue.sv -----
// Two-entry queue of classified words between the front end and the back end.
module itra_queue #(
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  itra_pkg::item_ctrl_t push_ctrl,
    input  logic [WORD_BITS-1:0] push_mag,
    input  logic                 pop,
    output logic                 full,
    output logic                 empty,
    output itra_pkg::item_ctrl_t head_ctrl,
    output logic [WORD_BITS-1:0] head_mag
);
    import itra_pkg::*;

    item_ctrl_t           ctrl_reg [2];
    logic [WORD_BITS-1:0] mag_reg  [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign head_ctrl = ctrl_reg[rd_ptr_reg];
    assign head_mag  = mag_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctrl_reg[wr_ptr_reg] <= push_ctrl;
            mag_reg[wr_ptr_reg]  <= push_mag;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

endmodule

// ----- hw/rtl/itra_back.sv -----
// Back end: iterative divider, digit stack and character output.
module itra_back #(
    parameter int WORD_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            empty,
    input  itra_pkg::item_ctrl_t            head_ctrl,
    input  logic [WORD_BITS-1:0]            head_mag,
    output logic                            pop,
    output logic                            strobe,
    output logic [itra_pkg::CHAR_W-1:0]     character,
    output logic                            last,
    output logic                            bad_radix
);
    import itra_pkg::*;

    localparam int STEPS    = (WORD_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS = STEPS * STEP_BITS;
    localparam int CNT_W    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int SP_W     = $clog2(WORD_BITS + 1);
    localparam int ADDR_W   = $clog2(WORD_BITS);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIVIDE = 4'b0010,
        ST_SIGN   = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [PAD_BITS-1:0]  dvd_reg, dvd_next;
    logic [DIGIT_W-1:0]   rem_reg, rem_next;
    logic [RADIX_W-1:0]   radix_reg, radix_next;
    logic                 minus_reg, minus_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SP_W-1:0]      sp_reg, sp_next;
    logic                 strobe_reg, strobe_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;
    logic                 bad_reg, bad_next;

    logic [PAD_BITS-1:0]  dvd_step;
    logic [DIGIT_W-1:0]   rem_step;
    logic                 push_digit;
    logic [SP_W-1:0]      rd_ptr;

    logic [DIGIT_W-1:0]   stack_mem [WORD_BITS];
    logic [DIGIT_W-1:0]   rd_data_reg;

    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign bad_radix = bad_reg;

    // Resolve STEP_BITS quotient bits by restoring division
    always_comb
    begin
        logic [RADIX_W-1:0]  part;
        logic [PAD_BITS-1:0] d;
        logic [DIGIT_W-1:0]  r;
        d = dvd_reg;
        r = rem_reg;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            part = {r, d[PAD_BITS-1]};
            d    = {d[PAD_BITS-2:0], 1'b0};
            if (part >= radix_reg)
            begin
                r    = DIGIT_W'(part - radix_reg);
                d[0] = 1'b1;
            end
            else
            begin
                r = part[DIGIT_W-1:0];
            end
        end
        dvd_step = d;
        rem_step = r;
    end

    // Sequence one word: report a bad radix, or load, divide per digit, sign, emit digits
    always_comb
    begin
        state_next  = state_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        radix_next  = radix_reg;
        minus_next  = minus_reg;
        cnt_next    = cnt_reg;
        sp_next     = sp_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;
        bad_next    = bad_reg;
        pop         = 1'b0;
        push_digit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (head_ctrl.bad)
                    begin
                        strobe_next = 1'b1;
                        char_next   = CHAR_NONE;
                        last_next   = 1'b1;
                        bad_next    = 1'b1;
                    end
                    else
                    begin
                        dvd_next   = PAD_BITS'(head_mag);
                        rem_next   = '0;
                        radix_next = head_ctrl.radix;
                        minus_next = head_ctrl.minus;
                        cnt_next   = '0;
                        sp_next    = '0;
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                dvd_next = dvd_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    push_digit = 1'b1;
                    sp_next    = sp_reg + 1'b1;
                    rem_next   = '0;
                    cnt_next   = '0;
                    if (dvd_step == '0)
                        state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (minus_reg)
                begin
                    strobe_next = 1'b1;
                    char_next   = CHAR_MINUS;
                    last_next   = 1'b0;
                    bad_next    = 1'b0;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                char_next   = digit_char(rd_data_reg);
                last_next   = (sp_reg == SP_W'(1));
                bad_next    = 1'b0;
                sp_next     = sp_reg - 1'b1;
                if (sp_reg == SP_W'(1))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Read ahead at the top of the stack as it will be next cycle
    assign rd_ptr = sp_next - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            sp_reg     <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            sp_reg     <= sp_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        minus_reg <= minus_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        bad_reg   <= bad_next;
    end

    // Push digits, least significant first
    always_ff @(posedge clk)
    begin
        if (push_digit)
            stack_mem[sp_reg[ADDR_W-1:0]] <= rem_step;
    end

    // Pop digits with a registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= stack_mem[rd_ptr[ADDR_W-1:0]];
    end

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && bad_radix) |-> (last && (character == CHAR_NONE)))
        else $error("error word without last or with text");

    a_text_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> (strobe && !bad_radix))
        else $error("gap inside the text of a number");

    a_stack_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> ((sp_reg != '0) && (sp_reg <= SP_W'(WORD_BITS))))
        else $error("digit stack out of range while emitting");

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (strobe || (state_reg == ST_DIVIDE)))
        else $error("popped word neither reported nor started");

endmodule

// ----- hw/rtl/integer_to_radix_ascii_top.sv -----
// Top level of the integer to radix ASCII text converter.
//
// Converts a signed integer to its text in radix 2..32, most significant digit
// first, one character per strobe, with last on the final character. A radix
// outside that range gives a single strobe with bad_radix and last set. A word
// is taken when start is high and busy is low; up to two words wait in a queue
// while the converter works on the current one, and busy is high only when the
// queue is full. Output strobes cannot be held off. The divider resolves eight
// quotient bits per cycle, and a word passes through the load, divide, sign and
// emit steps in turn; a word with a bad radix is reported from the idle state.
module integer_to_radix_ascii_top #(
    parameter int WORD_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [itra_pkg::NUMBER_W-1:0] number,
    input  logic [itra_pkg::RADIX_W-1:0]     radix,
    output logic                             strobe,
    output logic [itra_pkg::CHAR_W-1:0]      character,
    output logic                             last,
    output logic                             bad_radix
);
    import itra_pkg::*;

    item_ctrl_t           front_ctrl;
    logic [WORD_BITS-1:0] front_mag;
    item_ctrl_t           head_ctrl;
    logic [WORD_BITS-1:0] head_mag;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    logic                 accept;

    assign busy   = q_full;
    assign accept = start && !q_full;

    itra_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .number (number),
        .radix  (radix),
        .ctrl   (front_ctrl),
        .mag    (front_mag)
    );

    itra_queue #(
        .WORD_BITS (WORD_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_ctrl (front_ctrl),
        .push_mag  (front_mag),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head_ctrl (head_ctrl),
        .head_mag  (head_mag)
    );

    itra_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head_ctrl (head_ctrl),
        .head_mag  (head_mag),
        .pop       (q_pop),
        .strobe    (strobe),
        .character (character),
        .last      (last),
        .bad_radix (bad_radix)
    );

endmodule

// ----- tb/testbench.sv -----
// Testbench for the integer to radix ASCII text converter: directed and random words.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import itra_pkg::*;

    localparam int WORD_BITS   = 32;
    localparam int SETTLE      = 200;      // longer than the slowest word
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS  = 40;

    // One character of expected text
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              bad;
    } text_char_t;

    // Predicts the text of each accepted word and checks the strobed characters
    class text_scoreboard;
        text_char_t expected_chars[$];
        int         words;
        int         bad_words;
        int         chars_checked;
        int         fails;

        function int pending();
            return expected_chars.size();
        endfunction

        task report_mismatch(input string msg);
            if (fails < MAX_PRINTS)
                $display("[%0t] mismatch: %s", $realtime, msg);
            fails++;
        endtask

        // Work out the characters one word produces
        function void add_word(input logic signed [NUMBER_W-1:0] value,
                               input logic [RADIX_W-1:0] base);
            logic [WORD_BITS-1:0] mag;
            logic [WORD_BITS-1:0] divisor;
            logic [DIGIT_W-1:0]   digs[WORD_BITS+1];
            logic [CHAR_W-1:0]    ch;
            logic                 neg;
            int                   nd;
            words++;
            if (base < MIN_RADIX || base > MAX_RADIX)
            begin
                bad_words++;
                expected_chars.push_back('{CHAR_NONE, 1'b1, 1'b1});
                return;
            end
            neg = value[NUMBER_W-1];
            mag = WORD_BITS'(value);
            // take the magnitude as unsigned so the most negative value prints whole
            if (neg)
                mag = ~mag + 1'b1;
            divisor = WORD_BITS'(base);
            nd = 0;
            do
            begin
                digs[nd] = DIGIT_W'(mag % divisor);
                mag = mag / divisor;
                nd++;
            end
            while (mag != 0);
            if (neg && base == DEC_RADIX)
                expected_chars.push_back('{CHAR_MINUS, 1'b0, 1'b0});
            for (int i = nd - 1; i >= 0; i--)
            begin
                if (digs[i] > 5'd9)
                    ch = CHAR_A + CHAR_W'(digs[i]) - 7'd10;
                else
                    ch = CHAR_ZERO + CHAR_W'(digs[i]);
                expected_chars.push_back('{ch, i == 0, 1'b0});
            end
        endfunction

        // Compare one strobed character with the oldest expectation
        task check_char(input logic [CHAR_W-1:0] ch, input logic lst, input logic bad);
            text_char_t want;
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character %h last %b bad_radix %b",
                                          ch, lst, bad));
                return;
            end
            want = expected_chars.pop_front();
            chars_checked++;
            if (ch !== want.ch)
                report_mismatch($sformatf("character %h, expected %h", ch, want.ch));
            if (lst !== want.last)
                report_mismatch($sformatf("last %b, expected %b on character %h",
                                          lst, want.last, want.ch));
            if (bad !== want.bad)
                report_mismatch($sformatf("bad_radix %b, expected %b on character %h",
                                          bad, want.bad, want.ch));
        endtask
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic signed [NUMBER_W-1:0]  number = '0;
    logic [RADIX_W-1:0]          radix = '0;
    logic                        strobe;
    logic [CHAR_W-1:0]           character;
    logic                        last;
    logic                        bad_radix;

    text_scoreboard sb;

    integer_to_radix_ascii_top #(.WORD_BITS(WORD_BITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .number    (number),
        .radix     (radix),
        .strobe    (strobe),
        .character (character),
        .last      (last),
        .bad_radix (bad_radix)
    );

    always #2 clk = ~clk;

    // Note accepted words, then check strobed characters
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.add_word(number, radix);
        if (rst_n && strobe)
            sb.check_char(character, last, bad_radix);
    end

    // Drop the run if it hangs
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    // Offer one word after idling idle_pct cycles in a hundred; hold start for the next word
    task send_word(input logic signed [NUMBER_W-1:0] value, input logic [RADIX_W-1:0] base,
                   input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        number <= value;
        radix  <= base;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Hold off the sender until every expected character has come
    task drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic signed [NUMBER_W-1:0] pick_number();
        logic signed [NUMBER_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 40);
            1: v = -$signed({1'b0, 31'($urandom_range(1, 40))});
            2: case ($urandom_range(0, 4))
                   0: v = 32'sh7FFF_FFFF;
                   1: v = 32'sh8000_0000;
                   2: v = -1;
                   3: v = 0;
                   default: v = 1;
               endcase
            3: v = $urandom | 32'h8000_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [RADIX_W-1:0] pick_radix();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return RADIX_W'($urandom_range(2, 32));
        if (r < 82)
            return DEC_RADIX;
        return RADIX_W'($urandom_range(0, 63));
    endfunction

    task random_words(input int count, input int idle_pct);
        for (int i = 0; i < count; i++)
            send_word(pick_number(), pick_radix(), idle_pct);
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, extremes, sign handling, digit range and bad radixes
        send_word(0, DEC_RADIX, 0);
        send_word(0, MIN_RADIX, 0);
        send_word(32'sh7FFF_FFFF, DEC_RADIX, 0);
        send_word(32'sh8000_0000, DEC_RADIX, 0);
        send_word(32'sh8000_0000, MIN_RADIX, 0);
        send_word(32'sh8000_0000, 6'd16, 0);
        send_word(32'sh8000_0000, MAX_RADIX, 0);
        send_word(32'sh7FFF_FFFF, MIN_RADIX, 0);
        send_word(-1, DEC_RADIX, 0);
        send_word(-1, MIN_RADIX, 0);
        send_word(-255, 6'd16, 0);
        send_word(31, MAX_RADIX, 0);
        send_word(-1234567890, DEC_RADIX, 0);
        send_word(9, DEC_RADIX, 0);
        send_word(10, 6'd11, 0);
        send_word(80, 6'd9, 0);
        send_word(12345, 6'd0, 0);
        send_word(-7, 6'd1, 0);
        send_word(99, 6'd33, 0);
        send_word(32'sh7FFF_FFFF, 6'd63, 0);
        send_word(35, 6'd36, 0);
        send_word(32'sh5555_5555, 6'd3, 0);
        drain();

        // sender idles rarely, then often, then never
        random_words(46, 14);
        drain();
        random_words(46, 57);
        drain();
        random_words(46, 0);
        drain();

        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d characters never arrived", sb.pending()));

        $display("Converted %0d words (%0d with a bad radix), %0d characters checked.",
                 sb.words, sb.bad_words, sb.chars_checked);
        $display("Radixes 0 to 63, signed extremes and idle gaps from none to frequent.");
        if (sb.fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/itra_pkg.sv
hw/rtl/itra_front.sv
hw/rtl/itra_queue.sv
hw/rtl/itra_back.sv
hw/rtl/integer_to_radix_ascii_top.sv
tb/testbench.sv
